### sv/wgm_pkg.sv
// wgm_pkg: types, character constants and helpers for the wildcard glob matcher
// used by wgm_cell, wildcard_glob_matcher and wgm_checker; no dependencies
package wgm_pkg;

    localparam int CH_W        = 16;
    localparam int PAT_MAX_DEF = 32;

    localparam logic [CH_W-1:0] CH_DOT      = 16'h002E;
    localparam logic [CH_W-1:0] CH_QUESTION = 16'h003F;
    localparam logic [CH_W-1:0] CH_STAR     = 16'h002A;
    localparam logic [CH_W-1:0] CH_UPPER_A  = 16'h0041;
    localparam logic [CH_W-1:0] CH_UPPER_Z  = 16'h005A;
    localparam logic [CH_W-1:0] CASE_DELTA  = 16'h0020;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SUBJ   = 2'd2,
        CMD_EMPTY  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd            cmd;
        logic [CH_W-1:0] ch;
        logic            last;
    } t_in_item;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out_item;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic            step;
        logic            restart;
        logic            wr_en;
        logic            ign_case;
        logic            sub_dot;
        logic [CH_W-1:0] ch;
        logic [CH_W-1:0] sub_fold;
    } t_cell_ctl;

    function automatic logic [CH_W-1:0] fold_char(input logic [CH_W-1:0] c, input logic ic);
        logic [CH_W-1:0] r;
        r = c;
        if (ic && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

### sv/wgm_cell.sv
// wgm_cell: one pattern position; holds its pattern character, the active bit
// of its prefix and the leading-star flag; depends on wgm_pkg
module wgm_cell #(
    parameter int PAT_MAX = wgm_pkg::PAT_MAX_DEF,
    parameter int IDX     = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wgm_pkg::t_cell_ctl          i_ctl,
    input  logic [$clog2(PAT_MAX+1)-1:0] i_len,
    input  logic [$clog2(PAT_MAX+1)-1:0] i_len_next,
    input  logic                        i_pre,
    input  logic                        i_lead,
    output logic                        o_pre,
    output logic                        o_closed,
    output logic                        o_lead
);

    localparam int LW   = $clog2(PAT_MAX + 1);
    localparam int PREV = (IDX == 0) ? 0 : IDX - 1;
    localparam logic [LW-1:0] MY_POS   = LW'(IDX);
    localparam logic [LW-1:0] PREV_POS = LW'(PREV);

    logic [wgm_pkg::CH_W-1:0] r_ch;
    logic                     r_lead;
    logic                     r_act;
    logic                     n_lead;
    logic                     n_act;

    logic w_en;
    logic w_star;
    logic w_quest;
    logic w_lit;
    logic w_match;
    logic w_closed;
    logic w_ch_wr;
    logic w_lead_wr;
    logic w_lead_new;

    assign w_en    = MY_POS < i_len;
    assign w_star  = r_ch == wgm_pkg::CH_STAR;
    assign w_quest = r_ch == wgm_pkg::CH_QUESTION;
    assign w_lit   = wgm_pkg::fold_char(r_ch, i_ctl.ign_case) == i_ctl.sub_fold;
    assign w_match = w_star || (w_quest && !i_ctl.sub_dot) || (!w_star && !w_quest && w_lit);

    // star closure ripples from the left neighbor
    assign w_closed = i_pre || (r_act && w_star && w_en);
    assign o_pre    = w_en && ((r_act && w_match) || (w_closed && w_star));
    assign o_closed = w_closed;
    assign o_lead   = (IDX == 0) ? 1'b1 : r_lead;

    assign w_ch_wr    = i_ctl.wr_en && (i_len == MY_POS);
    assign w_lead_wr  = (IDX != 0) && i_ctl.wr_en && (i_len == PREV_POS);
    assign w_lead_new = i_lead && (i_ctl.ch == wgm_pkg::CH_STAR);

    always_comb begin
        n_lead = w_lead_wr ? w_lead_new : r_lead;
        n_act  = r_act;
        if (i_ctl.restart) begin
            n_act = ((IDX == 0) ? 1'b1 : n_lead) && (MY_POS <= i_len_next);
        end else if (i_ctl.step) begin
            n_act = w_closed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ch_wr) begin
            r_ch <= i_ctl.ch;
        end
        r_lead <= n_lead;
        if (!i_rst_n) begin
            r_act <= (IDX == 0);
        end else begin
            r_act <= n_act;
        end
    end

endmodule

### sv/wildcard_glob_matcher.sv
// wildcard_glob_matcher: top level, control and a row of wgm_cell instances
// depends on wgm_pkg and wgm_cell
//
// Usage: the input channel carries one command per transaction: clear the
// pattern, append one pattern character, stream one subject character (last
// marks the end of the subject), or ask for the empty subject. Each pattern
// position is one cell that holds its character and the active bit of its
// prefix; all cells update once per subject character and the star closure
// ripples through the row in the same cycle.
// Throughput: one transaction per cycle, every command kind, while the output is not stalled.
// Latency: a result appears on the output channel the cycle after the
// transaction with last set (or the empty-subject command) is accepted.
// Only that transaction gives a result; the others give none.
// When the receiver stalls, the result waits in the output register and the
// input side stops taking transactions until it is taken.
// Reset: pattern empty, overflow clear, ignore_case 0, no result pending.
// The ignore_case register is written through i_cfg_we / i_cfg_wdata.
module wildcard_glob_matcher #(
    parameter int PAT_MAX = wgm_pkg::PAT_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wgm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wgm_pkg::t_out_item o_out_data
);

    localparam int LW = $clog2(PAT_MAX + 1);
    localparam logic [LW-1:0] LEN_FULL = LW'(PAT_MAX);

    logic [LW-1:0]      r_len;
    logic [LW-1:0]      n_len;
    logic               r_ovf;
    logic               n_ovf;
    logic               r_ign_case;
    logic               r_out_valid;
    logic               n_out_valid;
    wgm_pkg::t_out_item r_out_data;
    wgm_pkg::t_out_item n_out_data;

    logic               w_accept;
    logic               w_emit;
    wgm_pkg::t_cell_ctl w_ctl;
    logic [PAT_MAX:0]   w_pre_in;
    logic [PAT_MAX:0]   w_pre_out;
    logic [PAT_MAX:0]   w_closed;
    logic [PAT_MAX:0]   w_lead;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_emit      = w_accept && ((i_in_data.cmd == wgm_pkg::CMD_SUBJ && i_in_data.last)
                                      || i_in_data.cmd == wgm_pkg::CMD_EMPTY);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        w_ctl.step     = w_accept && i_in_data.cmd == wgm_pkg::CMD_SUBJ && !i_in_data.last;
        w_ctl.restart  = w_accept && (i_in_data.cmd != wgm_pkg::CMD_SUBJ || i_in_data.last);
        w_ctl.wr_en    = w_accept && i_in_data.cmd == wgm_pkg::CMD_APPEND && r_len < LEN_FULL;
        w_ctl.ign_case = r_ign_case;
        w_ctl.sub_dot  = i_in_data.ch == wgm_pkg::CH_DOT;
        w_ctl.ch       = i_in_data.ch;
        w_ctl.sub_fold = wgm_pkg::fold_char(i_in_data.ch, r_ign_case);
    end

    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        if (w_accept && i_in_data.cmd == wgm_pkg::CMD_CLEAR) begin
            n_len = '0;
            n_ovf = 1'b0;
        end else if (w_ctl.wr_en) begin
            n_len = r_len + LW'(1);
        end else if (w_accept && i_in_data.cmd == wgm_pkg::CMD_APPEND) begin
            n_ovf = 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_data.pattern_overflow = r_ovf;
            n_out_data.matched = !r_ovf && ((i_in_data.cmd == wgm_pkg::CMD_EMPTY)
                                            ? w_lead[r_len] : w_closed[r_len]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_ign_case  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_ign_case <= i_cfg_wdata;
            end
        end
    end

    for (genvar g = 0; g <= PAT_MAX; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_pre_in[g] = 1'b0;
        end else begin : g_rest
            assign w_pre_in[g] = w_pre_out[g-1];
        end

        wgm_cell #(
            .PAT_MAX (PAT_MAX),
            .IDX     (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_len      (r_len),
            .i_len_next (n_len),
            .i_pre      (w_pre_in[g]),
            .i_lead     ((g == 0) ? 1'b1 : w_lead[(g == 0) ? 0 : g-1]),
            .o_pre      (w_pre_out[g]),
            .o_closed   (w_closed[g]),
            .o_lead     (w_lead[g])
        );
    end

    // the tail cell is never enabled, its outgoing transition stays low
    logic w_tail_pre;
    assign w_tail_pre = w_pre_out[PAT_MAX];

    always_ff @(posedge i_clk) begin
        if (w_tail_pre && i_rst_n) begin
            $error("tail cell produced a transition");
        end
    end

endmodule

### sv/wgm_checker.sv
// wgm_port_checks: port-level assertions for wildcard_glob_matcher, bound to it
// depends on wgm_pkg and the top level's ports
module wgm_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input wgm_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input wgm_pkg::t_out_item o_out_data
);

    logic w_acc;
    assign w_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.matched && o_out_data.pattern_overflow))
        else $error("match reported with pattern overflow");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_in_data.cmd == wgm_pkg::CMD_EMPTY |=> o_out_valid)
        else $error("empty subject gave no result");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_acc && i_in_data.cmd == wgm_pkg::CMD_CLEAR)
        && w_acc && i_in_data.cmd == wgm_pkg::CMD_EMPTY |=> o_out_data.matched)
        else $error("empty pattern failed to match empty subject");

endmodule

bind wildcard_glob_matcher wgm_port_checks u_wgm_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### dv/wgm_checker.sv
// wgm_checker: watches the channels of wildcard_glob_matcher, predicts each match result
// and compares it with what the block returns; depends on wgm_pkg
`timescale 1ns / 1ps
module wgm_checker #(
    parameter int PAT_MAX = wgm_pkg::PAT_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  wgm_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  wgm_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results
);

    localparam logic [PAT_MAX:0] EMPTY_PREFIX = {{PAT_MAX{1'b0}}, 1'b1};

    logic [wgm_pkg::CH_W-1:0] glob_chars [PAT_MAX];
    int                       glob_len;
    logic [PAT_MAX:0]         live_prefixes;
    logic                     glob_overflow;
    logic                     fold_on;
    wgm_pkg::t_out_item       verdict_q [$];

    function automatic logic [wgm_pkg::CH_W-1:0] case_fold(input logic [wgm_pkg::CH_W-1:0] c);
        if (fold_on && c >= wgm_pkg::CH_UPPER_A && c <= wgm_pkg::CH_UPPER_Z) begin
            return c + wgm_pkg::CASE_DELTA;
        end
        return c;
    endfunction

    function automatic logic [PAT_MAX:0] close_over_stars(input logic [PAT_MAX:0] v);
        for (int i = 0; i < glob_len; i++) begin
            if (v[i] && glob_chars[i] == wgm_pkg::CH_STAR) begin
                v[i+1] = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic logic [PAT_MAX:0] advance_prefixes(input logic [wgm_pkg::CH_W-1:0] c);
        logic [PAT_MAX:0] nxt;
        nxt = '0;
        for (int i = 0; i < glob_len; i++) begin
            if (live_prefixes[i]) begin
                if (glob_chars[i] == wgm_pkg::CH_STAR) begin
                    nxt[i]   = 1'b1;
                    nxt[i+1] = 1'b1;
                end else if (glob_chars[i] == wgm_pkg::CH_QUESTION) begin
                    if (c != wgm_pkg::CH_DOT) begin
                        nxt[i+1] = 1'b1;
                    end
                end else if (case_fold(glob_chars[i]) == case_fold(c)) begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        return close_over_stars(nxt);
    endfunction

    function automatic wgm_pkg::t_out_item current_verdict();
        wgm_pkg::t_out_item v;
        v.pattern_overflow = glob_overflow;
        v.matched          = !glob_overflow && live_prefixes[glob_len];
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        wgm_pkg::t_out_item want;
        if (!i_rst_n) begin
            glob_len      = 0;
            glob_overflow = 1'b0;
            fold_on       = 1'b0;
            live_prefixes = EMPTY_PREFIX;
            verdict_q     = {};
            o_fail_count  = 0;
            o_results     = 0;
        end else begin
            if (i_cfg_we) begin
                fold_on = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (verdict_q.size() == 0) begin
                    report_mismatch("result with no transaction waiting for one");
                end else begin
                    want = verdict_q.pop_front();
                    if (i_out_data.matched !== want.matched) begin
                        report_mismatch($sformatf("matched expected %0b got %0b",
                                                  want.matched, i_out_data.matched));
                    end
                    if (i_out_data.pattern_overflow !== want.pattern_overflow) begin
                        report_mismatch($sformatf("pattern_overflow expected %0b got %0b",
                                                  want.pattern_overflow,
                                                  i_out_data.pattern_overflow));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.cmd)
                    wgm_pkg::CMD_CLEAR: begin
                        glob_len      = 0;
                        glob_overflow = 1'b0;
                        live_prefixes = close_over_stars(EMPTY_PREFIX);
                    end
                    wgm_pkg::CMD_APPEND: begin
                        if (glob_len < PAT_MAX) begin
                            glob_chars[glob_len] = i_in_data.ch;
                            glob_len++;
                        end else begin
                            glob_overflow = 1'b1;
                        end
                        live_prefixes = close_over_stars(EMPTY_PREFIX);
                    end
                    wgm_pkg::CMD_SUBJ: begin
                        live_prefixes = advance_prefixes(i_in_data.ch);
                        if (i_in_data.last) begin
                            verdict_q.push_back(current_verdict());
                            live_prefixes = close_over_stars(EMPTY_PREFIX);
                        end
                    end
                    default: begin
                        live_prefixes = close_over_stars(EMPTY_PREFIX);
                        verdict_q.push_back(current_verdict());
                    end
                endcase
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

### dv/wildcard_glob_matcher_tb.sv
// wildcard_glob_matcher_tb: drives patterns and subjects into wildcard_glob_matcher under
// several handshake phases and gives the verdict; depends on wgm_pkg and wgm_checker
`timescale 1ns / 1ps
module wildcard_glob_matcher_tb;

    localparam int PAT_MAX         = wgm_pkg::PAT_MAX_DEF;
    localparam int ITEMS_PER_PHASE = 325;
    localparam int QUIET_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 3;

    typedef logic [wgm_pkg::CH_W-1:0] t_char;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_wdata = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    wgm_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    wgm_pkg::t_out_item out_data;

    int fail_count;
    int pending;
    int results;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    t_char glob_q [$];

    wildcard_glob_matcher #(.PAT_MAX(PAT_MAX)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    wgm_checker #(.PAT_MAX(PAT_MAX)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    always #1 clk = ~clk;

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic push_item(input wgm_pkg::t_cmd cmd, input t_char ch, input logic last);
        wgm_pkg::t_in_item it;
        it.cmd  = cmd;
        it.ch   = ch;
        it.last = last;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_verdicts();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_fold(input logic value);
        wait_for_verdicts();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic is_letter(input t_char c);
        return (c >= wgm_pkg::CH_UPPER_A && c <= wgm_pkg::CH_UPPER_Z) ||
               (c >= wgm_pkg::CH_UPPER_A + wgm_pkg::CASE_DELTA &&
                c <= wgm_pkg::CH_UPPER_Z + wgm_pkg::CASE_DELTA);
    endfunction

    function automatic t_char pick_text_char();
        int r;
        r = $urandom_range(15);
        if (r <= 8) begin
            return t_char'(wgm_pkg::CH_UPPER_A + $urandom_range(2)
                           + ($urandom_range(1) ? wgm_pkg::CASE_DELTA : '0));
        end else if (r == 9) begin
            return wgm_pkg::CH_DOT;
        end else if (r == 10) begin
            return wgm_pkg::CH_STAR;
        end else if (r == 11) begin
            return wgm_pkg::CH_QUESTION;
        end else if (r == 12) begin
            case ($urandom_range(3))
                0:       return t_char'(wgm_pkg::CH_UPPER_A - 1);
                1:       return t_char'(wgm_pkg::CH_UPPER_Z + 1);
                2:       return t_char'(wgm_pkg::CH_UPPER_A + wgm_pkg::CASE_DELTA - 1);
                default: return t_char'(wgm_pkg::CH_UPPER_Z + wgm_pkg::CASE_DELTA + 1);
            endcase
        end
        return t_char'($urandom_range(65535));
    endfunction

    function automatic t_char pick_glob_char();
        int r;
        r = $urandom_range(15);
        if (r <= 2) begin
            return wgm_pkg::CH_STAR;
        end else if (r <= 4) begin
            return wgm_pkg::CH_QUESTION;
        end
        return pick_text_char();
    endfunction

    task automatic noise_item();
        wgm_pkg::t_cmd cmd;
        t_char         ch;
        cmd = wgm_pkg::t_cmd'($urandom_range(3));
        ch  = t_char'($urandom_range(65535));
        if (cmd == wgm_pkg::CMD_CLEAR) begin
            glob_q = {};
        end else if (cmd == wgm_pkg::CMD_APPEND) begin
            glob_q.push_back(ch);
        end
        push_item(cmd, ch, 1'($urandom_range(1)));
    endtask

    // subject derived from the current pattern, sometimes mutated or cut short
    task automatic run_subject();
        t_char text [$];
        t_char c;
        int    cut;
        text = {};
        foreach (glob_q[i]) begin
            if (glob_q[i] == wgm_pkg::CH_STAR) begin
                repeat ($urandom_range(3)) text.push_back(pick_text_char());
            end else if (glob_q[i] == wgm_pkg::CH_QUESTION) begin
                text.push_back(pick_text_char());
            end else begin
                c = glob_q[i];
                if (is_letter(c) && $urandom_range(1)) begin
                    c = c ^ wgm_pkg::CASE_DELTA;
                end
                text.push_back(c);
            end
        end
        if ($urandom_range(4) == 0) begin
            case ($urandom_range(2))
                0: if (text.size() > 0) text.delete($urandom_range(text.size() - 1));
                1: text.insert($urandom_range(text.size()), pick_text_char());
                default: if (text.size() > 0) text[$urandom_range(text.size() - 1)] =
                                                  pick_text_char();
            endcase
        end
        cut = ($urandom_range(19) == 0) ? $urandom_range(text.size()) : -1;
        if (text.size() == 0) begin
            push_item(wgm_pkg::CMD_EMPTY, t_char'($urandom_range(65535)),
                      1'($urandom_range(1)));
        end else begin
            foreach (text[i]) begin
                if (i == cut) begin
                    noise_item();
                    return;
                end
                push_item(wgm_pkg::CMD_SUBJ, text[i], i == text.size() - 1);
            end
        end
    endtask

    task automatic run_sequence();
        int    glob_len;
        t_char c;
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 3)) noise_item();
            return;
        end
        push_item(wgm_pkg::CMD_CLEAR, t_char'($urandom_range(65535)), 1'($urandom_range(1)));
        glob_q   = {};
        glob_len = ($urandom_range(15) == 0) ? $urandom_range(PAT_MAX - 4, PAT_MAX + 4)
                                             : $urandom_range(8);
        repeat (glob_len) begin
            c = pick_glob_char();
            glob_q.push_back(c);
            push_item(wgm_pkg::CMD_APPEND, c, 1'($urandom_range(1)));
        end
        repeat ($urandom_range(1, 4)) run_subject();
    endtask

    task automatic run_directed();
        push_item(wgm_pkg::CMD_CLEAR, 16'hFFFF, 1'b1);
        push_item(wgm_pkg::CMD_EMPTY, 16'h0000, 1'b0);
        push_item(wgm_pkg::CMD_SUBJ, 16'h0078, 1'b1);
        push_item(wgm_pkg::CMD_APPEND, wgm_pkg::CH_STAR, 1'b1);
        push_item(wgm_pkg::CMD_EMPTY, 16'hFFFF, 1'b1);
        push_item(wgm_pkg::CMD_APPEND, wgm_pkg::CH_QUESTION, 1'b0);
        push_item(wgm_pkg::CMD_APPEND, t_char'(wgm_pkg::CH_UPPER_A + 1), 1'b0);
        push_item(wgm_pkg::CMD_SUBJ, wgm_pkg::CH_DOT, 1'b0);
        push_item(wgm_pkg::CMD_SUBJ, 16'h007A, 1'b0);
        push_item(wgm_pkg::CMD_SUBJ, t_char'(wgm_pkg::CH_UPPER_A + 1), 1'b1);
        push_item(wgm_pkg::CMD_SUBJ, wgm_pkg::CH_DOT, 1'b0);
        push_item(wgm_pkg::CMD_SUBJ, t_char'(wgm_pkg::CH_UPPER_A + 1), 1'b1);
        push_item(wgm_pkg::CMD_SUBJ, 16'h0078, 1'b0);
        push_item(wgm_pkg::CMD_SUBJ,
                  t_char'(wgm_pkg::CH_UPPER_A + wgm_pkg::CASE_DELTA + 1), 1'b1);
        // append while a subject is in progress
        push_item(wgm_pkg::CMD_SUBJ, 16'h0078, 1'b0);
        push_item(wgm_pkg::CMD_APPEND,
                  t_char'(wgm_pkg::CH_UPPER_A + wgm_pkg::CASE_DELTA + 2), 1'b0);
        // empty subject while one is in progress
        push_item(wgm_pkg::CMD_SUBJ, 16'hFFFF, 1'b0);
        push_item(wgm_pkg::CMD_EMPTY, 16'h0000, 1'b0);
        push_item(wgm_pkg::CMD_SUBJ, 16'h0000, 1'b0);
        push_item(wgm_pkg::CMD_SUBJ, t_char'(wgm_pkg::CH_UPPER_A + 1), 1'b0);
        push_item(wgm_pkg::CMD_SUBJ, t_char'(wgm_pkg::CH_UPPER_A + 2), 1'b1);
        write_fold(1'b1);
        push_item(wgm_pkg::CMD_SUBJ, 16'h0000, 1'b0);
        push_item(wgm_pkg::CMD_SUBJ,
                  t_char'(wgm_pkg::CH_UPPER_A + wgm_pkg::CASE_DELTA + 1), 1'b0);
        push_item(wgm_pkg::CMD_SUBJ, t_char'(wgm_pkg::CH_UPPER_A + 2), 1'b1);
    endtask

    initial begin
        int send_pct [4];
        int recv_pct [4];
        int phase_start;
        logic paused;
        send_pct = '{0, 63, 0, 25};
        recv_pct = '{0, 0, 63, 25};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        for (int ph = 0; ph < 4; ph++) begin
            write_fold(1'(ph % 2));
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            phase_start    = items_sent;
            paused         = 1'b0;
            while (items_sent < phase_start + ITEMS_PER_PHASE) begin
                if (!paused && items_sent >= phase_start + ITEMS_PER_PHASE / 2) begin
                    wait_for_verdicts();
                    paused = 1'b1;
                end
                run_sequence();
            end
        end
        wait_for_verdicts();
        repeat (8) @(negedge clk);
        $display("covered %0d input transactions and %0d match results", items_sent, results);
        $display("over four handshake phases with ignore_case at 0 and 1");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
sv/wgm_pkg.sv
sv/wgm_cell.sv
sv/wildcard_glob_matcher.sv
sv/wgm_checker.sv
dv/wgm_checker.sv
dv/wildcard_glob_matcher_tb.sv
